[rtl/core/scan_observation_dedup_filter_top_macros.svh]
// Assertion macros for the scan observation dedup filter.
// Used by files that assert; they need clk and rst in scope.
`ifndef SCAN_OBSERVATION_DEDUP_FILTER_TOP_MACROS_SVH
`define SCAN_OBSERVATION_DEDUP_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SODF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define SODF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/core/sodf_pkg.sv]
// Shared types and constants for the scan observation dedup filter.
// No dependencies; the interfaces, modules and testbench import this package.
`timescale 1ns / 1ps
package sodf_pkg;

  localparam int TABLE_ENTRIES = 24;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ADDR_W = 48;
  localparam int KEY_W = 50;
  localparam int TS_W = 48;
  localparam int TAG_W = 32;

  localparam logic [15:0] INTERVAL_RESET = 16'd250;
  localparam logic OP_CLEAR = 1'b1;

  // Stored flag bits.
  localparam int FLG_CONN = 0;
  localparam int FLG_HID = 1;
  localparam int FLG_KBD = 2;
  localparam int FLG_NAME = 3;

  // Decision codes.
  localparam logic [2:0] DEC_NO_SIGNAL = 3'd0;
  localparam logic [2:0] DEC_QUEUE_FULL = 3'd1;
  localparam logic [2:0] DEC_RATE_LIMITED = 3'd2;
  localparam logic [2:0] DEC_NEW_SIGNAL = 3'd3;
  localparam logic [2:0] DEC_INTERVAL = 3'd4;
  localparam logic [2:0] DEC_CLEARED = 3'd5;

  typedef struct packed {
    logic opcode;
    logic [ADDR_W-1:0] device_address;
    logic [1:0] address_kind;
    logic [7:0] adv_kind;
    logic has_name;
    logic [TAG_W-1:0] name_tag;
    logic hid_service_seen;
    logic keyboard_look_seen;
    logic [TS_W-1:0] timestamp_ms;
    logic queue_has_room;
  } report_t;

  typedef struct packed {
    logic forward;
    logic [2:0] decision;
    logic [4:0] slot;
    logic slot_reallocated;
  } result_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic scan;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic need_scan;
    logic scan_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[rtl/core/sodf_if.sv]
// Valid/ready channel interfaces for reports and results.
// Depends on sodf_pkg.
`timescale 1ns / 1ps
interface sodf_report_if import sodf_pkg::*;;
  logic valid;
  logic ready;
  report_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sodf_result_if import sodf_pkg::*;;
  logic valid;
  logic ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/sodf_ctrl.sv]
// Controller state machine for the dedup filter.
// Depends on sodf_pkg; drives the datapath by command and status structs.
`timescale 1ns / 1ps
module sodf_ctrl import sodf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Commands and next state.
  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (!sts.special && sts.need_scan) state_next = ST_SCAN;
        else state_next = ST_DECIDE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = !sts.out_busy;
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

[rtl/core/sodf_dp.sv]
// Datapath of the dedup filter: report register, device table, oldest
// search, decision logic and result register. Depends on sodf_pkg.
`timescale 1ns / 1ps
module sodf_dp import sodf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  input  report_t in_payload,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output result_t out_payload
);

  logic [15:0] interval;
  report_t rpt;

  logic entry_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0] entry_key [TABLE_ENTRIES];
  logic [3:0] entry_flags [TABLE_ENTRIES];
  logic [TAG_W-1:0] entry_name_tag [TABLE_ENTRIES];
  logic [TS_W-1:0] entry_last [TABLE_ENTRIES];

  logic [IDX_W-1:0] slot;
  logic realloc;
  logic [IDX_W-1:0] cnt;
  logic [TS_W-1:0] best_ts;

  logic [KEY_W-1:0] key;
  logic [3:0] obs;
  logic hit, have_free;
  logic [IDX_W-1:0] hit_idx, free_idx, rd_idx;
  logic [TS_W-1:0] last_rd, last_eff;
  logic [3:0] stored;
  logic adds, passed, fwd;
  logic [TS_W-1:0] elapsed;
  result_t res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) interval <= INTERVAL_RESET;
    else if (cfg_we) interval <= cfg_wdata;
  end

  // Report register.
  always_ff @(posedge clk) begin
    if (cmd.load) rpt <= in_payload;
  end

  assign key = {rpt.address_kind, rpt.device_address};
  assign obs[FLG_CONN] = (rpt.adv_kind == 8'd0) || (rpt.adv_kind == 8'd1);
  assign obs[FLG_HID] = rpt.hid_service_seen;
  assign obs[FLG_KBD] = rpt.keyboard_look_seen;
  assign obs[FLG_NAME] = rpt.has_name;

  // Parallel key match and first free entry, lowest index first.
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    have_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit && entry_valid[i] && entry_key[i] == key) begin
        hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!have_free && !entry_valid[i]) begin
        have_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign sts.special = (rpt.opcode == OP_CLEAR) || (obs == 4'd0) || !rpt.queue_has_room;
  assign sts.need_scan = !hit && !have_free;
  assign sts.scan_last = (cnt == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.out_busy = out_valid && !out_ready;

  // One read port into the time array, shared by the scan and the decision.
  assign rd_idx = cmd.scan ? cnt : slot;
  assign last_rd = entry_last[rd_idx];

  // Slot selection and the oldest-entry scan, one entry per cycle.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot <= hit ? hit_idx : free_idx;
      realloc <= !hit;
      cnt <= '0;
      best_ts <= '1;
    end else if (cmd.scan) begin
      cnt <= cnt + IDX_W'(1);
      if (last_rd < best_ts) begin
        best_ts <= last_rd;
        slot <= cnt;
      end
    end
  end

  // Forwarding decision; a newly taken entry reads as empty.
  assign stored = realloc ? 4'd0 : entry_flags[slot];
  assign last_eff = realloc ? '0 : last_rd;
  assign elapsed = rpt.timestamp_ms - last_eff;
  assign passed = (rpt.timestamp_ms >= last_eff) && (elapsed >= TS_W'(interval));
  always_comb begin
    adds = ((obs[2:0] & ~stored[2:0]) != 3'd0);
    if (obs[FLG_NAME] && (!stored[FLG_NAME] || entry_name_tag[slot] != rpt.name_tag)) begin
      adds = 1'b1;
    end
  end
  assign fwd = adds || passed;

  // Result value.
  always_comb begin
    res = '0;
    if (rpt.opcode == OP_CLEAR) begin
      res.decision = DEC_CLEARED;
    end else if (obs == 4'd0) begin
      res.decision = DEC_NO_SIGNAL;
    end else if (!rpt.queue_has_room) begin
      res.decision = DEC_QUEUE_FULL;
    end else begin
      res.forward = fwd;
      res.decision = !fwd ? DEC_RATE_LIMITED : (adds ? DEC_NEW_SIGNAL : DEC_INTERVAL);
      res.slot = 5'(slot);
      res.slot_reallocated = realloc;
    end
  end

  // Table update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) entry_valid[i] <= 1'b0;
    end else if (cmd.decide) begin
      if (rpt.opcode == OP_CLEAR) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) entry_valid[i] <= 1'b0;
      end else if (!sts.special && realloc) begin
        entry_valid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && !sts.special) begin
      if (realloc) entry_key[slot] <= key;
      if (fwd) begin
        entry_flags[slot] <= stored | obs;
        if (obs[FLG_NAME]) entry_name_tag[slot] <= rpt.name_tag;
        entry_last[slot] <= rpt.timestamp_ms;
      end else if (realloc) begin
        entry_flags[slot] <= 4'd0;
        entry_last[slot] <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.decide) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) out_payload <= res;
  end

endmodule

[rtl/core/scan_observation_dedup_filter_top.sv]
// Scan observation dedup filter: takes one report per transaction, looks the
// device up in a 24-entry table and returns one forward decision. An accepted
// report passes a lookup step and a decision step, which loads the result
// register, and the filter then returns to idle to take the next report, when
// the device hits or a free entry exists. A miss into a full table adds a scan
// step before the decision, where the oldest entry is found by comparing one
// entry per cycle. Clear, no-signal and queue-full transactions never scan. A
// new report is taken while the previous result waits in the output register;
// the decision step of that report then waits until the output register is free.
`timescale 1ns / 1ps
`include "scan_observation_dedup_filter_top_macros.svh"
module scan_observation_dedup_filter_top import sodf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  sodf_report_if.sink report,
  sodf_result_if.source result
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  sodf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(report.valid), .in_ready(report.ready),
    .sts(sts), .cmd(cmd)
  );

  // Table and decision datapath.
  sodf_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_payload(report.payload), .cmd(cmd), .sts(sts),
    .out_valid(result.valid), .out_ready(result.ready), .out_payload(result.payload)
  );

  // An accepted report leaves the filter busy, not ready for another report.
  `SODF_ASSERT_NXT(a_busy_after_accept, report.valid && report.ready, !report.ready)
  // Only the new-signal and interval decisions forward.
  `SODF_ASSERT_IMP(a_fwd_code, result.valid && result.payload.forward,
    result.payload.decision == DEC_NEW_SIGNAL || result.payload.decision == DEC_INTERVAL)
  // A freshly taken entry always brings new signal.
  `SODF_ASSERT_IMP(a_realloc_new, result.valid && result.payload.slot_reallocated,
    result.payload.forward && result.payload.decision == DEC_NEW_SIGNAL)

endmodule

[test/tb_scan_observation_dedup_filter_top.sv]
// Self-checking testbench for the scan observation dedup filter top level.
// Depends on sodf_pkg, sodf_if and scan_observation_dedup_filter_top; it keeps
// its own table model, drives reports with random gaps and checks every result.
`timescale 1ns / 1ps
module tb_scan_observation_dedup_filter_top;
  import sodf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  sodf_report_if report ();
  sodf_result_if result ();

  scan_observation_dedup_filter_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .report(report),
    .result(result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the device table and the interval register.
  logic [15:0] mdl_interval;
  logic mdl_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0] mdl_key [TABLE_ENTRIES];
  logic [3:0] mdl_flags [TABLE_ENTRIES];
  logic [TAG_W-1:0] mdl_tag [TABLE_ENTRIES];
  logic [TS_W-1:0] mdl_last [TABLE_ENTRIES];

  report_t pending_reports[$];
  result_t expected_decisions[$];
  int errors = 0;
  bit stim_done = 0;

  // Small pool of devices so that hits, evictions and rate limiting occur.
  logic [ADDR_W-1:0] dev_addr [40];
  logic [1:0] dev_kind [40];
  logic [TS_W-1:0] clock_ms;

  task automatic table_reset();
    mdl_interval = INTERVAL_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      mdl_valid[i] = 1'b0;
    end
  endtask

  // Computes the forward decision for one report and updates the table.
  function automatic result_t decide_report(report_t r);
    result_t o;
    logic [KEY_W-1:0] k;
    logic [3:0] obs;
    logic [3:0] st;
    logic adds;
    logic hit;
    int s;
    o = '0;
    hit = 1'b0;
    s = 0;
    if (r.opcode == OP_CLEAR) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) mdl_valid[i] = 1'b0;
      o.decision = DEC_CLEARED;
      return o;
    end
    k = {r.address_kind, r.device_address};
    obs = '0;
    obs[FLG_CONN] = (r.adv_kind == 8'd0) || (r.adv_kind == 8'd1);
    obs[FLG_HID] = r.hid_service_seen;
    obs[FLG_KBD] = r.keyboard_look_seen;
    obs[FLG_NAME] = r.has_name;
    if (obs == '0) begin
      o.decision = DEC_NO_SIGNAL;
      return o;
    end
    if (!r.queue_has_room) begin
      o.decision = DEC_QUEUE_FULL;
      return o;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit && mdl_valid[i] && mdl_key[i] == k) begin
        hit = 1'b1;
        s = i;
      end
    end
    if (!hit) begin
      // First free entry, else the oldest one with the lowest index on a tie.
      s = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (s < 0 && !mdl_valid[i]) s = i;
      end
      if (s < 0) begin
        s = 0;
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
          if (mdl_last[i] < mdl_last[s]) s = i;
        end
      end
      mdl_valid[s] = 1'b1;
      mdl_key[s] = k;
      mdl_flags[s] = '0;
      mdl_tag[s] = '0;
      mdl_last[s] = '0;
    end
    st = mdl_flags[s];
    adds = |(obs[2:0] & ~st[2:0]);
    if (obs[FLG_NAME] && (!st[FLG_NAME] || mdl_tag[s] != r.name_tag)) adds = 1'b1;
    o.slot = s[4:0];
    o.slot_reallocated = !hit;
    if (adds || (r.timestamp_ms >= mdl_last[s] &&
                 r.timestamp_ms - mdl_last[s] >= {32'd0, mdl_interval})) begin
      mdl_flags[s] = st | obs;
      if (obs[FLG_NAME]) mdl_tag[s] = r.name_tag;
      mdl_last[s] = r.timestamp_ms;
      o.forward = 1'b1;
      o.decision = adds ? DEC_NEW_SIGNAL : DEC_INTERVAL;
    end else begin
      o.decision = DEC_RATE_LIMITED;
    end
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random report about a pooled device, mostly with signal and room.
  function automatic report_t random_report();
    report_t r;
    int d;
    r = '0;
    d = $urandom_range(0, 39);
    r.opcode = ($urandom_range(0, 99) == 0);
    r.device_address = ($urandom_range(0, 19) == 0) ?
                       48'({$urandom, $urandom}) : dev_addr[d];
    r.address_kind = dev_kind[d];
    r.adv_kind = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    r.has_name = 1'($urandom_range(0, 1));
    r.name_tag = ($urandom_range(0, 3) == 0) ? $urandom : {30'd0, 2'(d)};
    r.hid_service_seen = 1'($urandom_range(0, 1));
    r.keyboard_look_seen = 1'($urandom_range(0, 1));
    clock_ms = clock_ms + 48'($urandom_range(0, 120));
    r.timestamp_ms = ($urandom_range(0, 29) == 0) ? 48'({$urandom, $urandom}) : clock_ms;
    r.queue_has_room = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  // Driver: presents queued reports with random gaps between transactions.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (report.valid && !report.ready) begin
      // Hold the current transaction.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      report.valid <= 1'b0;
    end else if (pending_reports.size() > 0) begin
      report.payload <= pending_reports[0];
      expected_decisions.push_back(decide_report(pending_reports[0]));
      void'(pending_reports.pop_front());
      report.valid <= 1'b1;
      send_gap <= gap_len();
    end else begin
      report.valid <= 1'b0;
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_decisions.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result.payload);
          errors++;
        end else begin
          if (result.payload !== expected_decisions[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time,
                     expected_decisions[0], result.payload);
            errors++;
          end
          void'(expected_decisions.pop_front());
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        stall <= gap_len();
      end
    end
  end

  // Waits until every queued report went out and every result came back.
  task automatic drain();
    while (pending_reports.size() > 0 || report.valid || expected_decisions.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_interval(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_interval = v;
  endtask

  // Stimulus: directed corner cases, then random phases over several intervals.
  initial begin
    report_t r;
    logic [15:0] settings [5];
    report.valid = 1'b0;
    report.payload = '0;
    result.ready = 1'b0;
    table_reset();
    clock_ms = 48'd1000;
    for (int i = 0; i < 40; i++) begin
      dev_addr[i] = 48'({$urandom, $urandom});
      dev_kind[i] = 2'($urandom);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Extremes, every decision, time going back and a name change.
    r = '0; r.adv_kind = 8'd5; r.queue_has_room = 1'b1;
    pending_reports.push_back(r);
    r.adv_kind = 8'd0; r.queue_has_room = 1'b0;
    pending_reports.push_back(r);
    r = '1; r.opcode = 1'b0; r.adv_kind = 8'hFF;
    pending_reports.push_back(r);
    pending_reports.push_back(r);
    r.timestamp_ms = r.timestamp_ms - 48'd1;
    pending_reports.push_back(r);
    r.name_tag = 32'h0;
    pending_reports.push_back(r);
    r.timestamp_ms = '1;
    r.adv_kind = 8'd1;
    pending_reports.push_back(r);
    r = '0; r.queue_has_room = 1'b1; r.hid_service_seen = 1'b1;
    r.timestamp_ms = 48'd300;
    pending_reports.push_back(r);
    r.timestamp_ms = 48'd549;
    pending_reports.push_back(r);
    r.timestamp_ms = 48'd550;
    pending_reports.push_back(r);
    r.opcode = OP_CLEAR;
    pending_reports.push_back(r);
    // Fill the table past its size so that evictions take place.
    for (int i = 0; i < 26; i++) begin
      r = '0; r.queue_has_room = 1'b1; r.keyboard_look_seen = 1'b1;
      r.device_address = 48'(i + 100);
      r.timestamp_ms = 48'(5000 - 7 * (i % 9));
      pending_reports.push_back(r);
    end
    drain();

    // Random phases, with the interval at its extremes and in between.
    settings[0] = 16'd0;
    settings[1] = 16'hFFFF;
    settings[2] = 16'd60;
    settings[3] = 16'($urandom);
    settings[4] = 16'd250;
    for (int ph = 0; ph < 5; ph++) begin
      write_interval(settings[ph]);
      for (int n = 0; n < 160; n++) pending_reports.push_back(random_report());
      drain();
    end
    stim_done = 1;
  end

  // Final verdict after all stimulus has drained.
  initial begin
    wait (stim_done);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a stuck handshake.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

[scan_observation_dedup_filter_top.f]
+incdir+rtl/core
rtl/core/sodf_pkg.sv
rtl/core/sodf_if.sv
rtl/core/sodf_ctrl.sv
rtl/core/sodf_dp.sv
rtl/core/scan_observation_dedup_filter_top.sv
test/tb_scan_observation_dedup_filter_top.sv
